@@ hdl/lash_pkg.sv @@
// Shared types, constants and stage counts for the Lambert plus ambient shader.
package lash_pkg;

	// Default coordinate width in bits (signed Q16.16 at 32).
	localparam int COORD_WIDTH_DEF = 32;
	// Width of every external coordinate field and of configuration data.
	localparam int FIELD_W = 32;
	// Reduced vector component width (magnitude below 2^15).
	localparam int RED_W = 16;
	// Square-root operand and result widths.
	localparam int SQ_IN_W = 64;
	localparam int ROOT_W = 32;
	// Quotient bits produced by the diffuse divider.
	localparam int DIV_BITS = 9;

	// Stage counts of the pipeline sections.
	localparam int FRONT_ST = 6;
	localparam int SQ_ST = ROOT_W / 2;
	localparam int DIV_ST = DIV_BITS + 1;
	localparam int OUT_ST = 2;
	localparam int NUM_ST = FRONT_ST + SQ_ST + DIV_ST + OUT_ST;

	// Vector slots in the front end.
	localparam int VEC_L = 0;
	localparam int VEC_V = 1;
	localparam int VEC_N = 2;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_LIGHT_X  = 3'd0,
		REG_LIGHT_Y  = 3'd1,
		REG_LIGHT_Z  = 3'd2,
		REG_CAMERA_X = 3'd3,
		REG_CAMERA_Y = 3'd4,
		REG_CAMERA_Z = 3'd5,
		REG_AMB_LVL  = 3'd6,
		REG_AMB_RGB  = 3'd7
	} cfg_reg_t;

	// Input transaction payload.
	typedef struct packed {
		logic signed [31:0] hit_x;
		logic signed [31:0] hit_y;
		logic signed [31:0] hit_z;
		logic signed [31:0] normal_x;
		logic signed [31:0] normal_y;
		logic signed [31:0] normal_z;
		logic [7:0]         surface_red;
		logic [7:0]         surface_green;
		logic [7:0]         surface_blue;
	} shade_in_t;

	// Output transaction payload.
	typedef struct packed {
		logic [16:0] shade_red;
		logic [16:0] shade_green;
		logic [16:0] shade_blue;
		logic        degenerate;
	} shade_out_t;

	// Values that ride alongside the arithmetic through the back half.
	typedef struct packed {
		logic [31:0]     dot;
		logic [2:0][7:0] col;
		logic            degen;
		logic            dpos;
	} side_t;

endpackage

@@ hdl/lash_front.sv @@
// Front end: vector forming, range reduction, dot products and the norm product.
module lash_front import lash_pkg::*; #(
	parameter int CW = COORD_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic [FRONT_ST-1:0]          en,
	input  shade_in_t                    item,
	input  logic [2:0][FIELD_W-1:0]      light,
	input  logic [2:0][FIELD_W-1:0]      camera,
	output logic [SQ_IN_W-1:0]           prod,
	output side_t                        side
);

	localparam int VW = CW + 1;
	localparam int KW = $clog2(VW + 1);

	// Keep the low CW bits of a field and read them as signed.
	function automatic logic signed [CW-1:0] sx(input logic [FIELD_W-1:0] f);
		return CW'(f);
	endfunction

	function automatic logic [VW-1:0] mag(input logic signed [VW-1:0] a);
		return a[VW-1] ? unsigned'(-a) : unsigned'(a);
	endfunction

	logic [FIELD_W-1:0] pt [3];
	logic [FIELD_W-1:0] nr [3];
	logic [2:0][7:0] col_c;

	logic signed [VW-1:0] vec_c [3][3];
	logic zl_c, zn_c;

	logic signed [VW-1:0] vec_s1 [3][3];
	logic [2:0][7:0] col_s1;
	logic degen_s1;

	logic [VW-1:0] max_c [3];
	logic signed [VW-1:0] vec_s2 [3][3];
	logic [VW-1:0] max_s2 [3];
	logic [2:0][7:0] col_s2;
	logic degen_s2;

	logic signed [RED_W-1:0] red_c [3][3];
	logic signed [RED_W-1:0] red_s3 [3][3];
	logic [2:0][7:0] col_s3;
	logic degen_s3;

	logic signed [31:0] lnp_c [3], vnp_c [3], llp_c [3], nnp_c [3];
	logic signed [31:0] lnp_s4 [3], vnp_s4 [3], llp_s4 [3], nnp_s4 [3];
	logic [2:0][7:0] col_s4;
	logic degen_s4;

	logic signed [33:0] dln_c, dvn_c, dd_c;
	logic [31:0] ll_c, nn_c;
	logic [31:0] ll_s5, nn_s5;
	side_t side_s5;

	logic [SQ_IN_W-1:0] prod_s6;
	side_t side_s6;

	// Unpack the transaction into per-axis arrays.
	always_comb begin
		pt[0] = item.hit_x;
		pt[1] = item.hit_y;
		pt[2] = item.hit_z;
		nr[0] = item.normal_x;
		nr[1] = item.normal_y;
		nr[2] = item.normal_z;
		col_c = {item.surface_blue, item.surface_green, item.surface_red};
	end

	// Stage 1: light and view vectors, zero-length tests.
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			vec_c[VEC_L][j] = VW'(sx(light[j])) - VW'(sx(pt[j]));
			vec_c[VEC_V][j] = VW'(sx(camera[j])) - VW'(sx(pt[j]));
			vec_c[VEC_N][j] = VW'(sx(nr[j]));
		end
		zl_c = (vec_c[VEC_L][0] == '0) && (vec_c[VEC_L][1] == '0) && (vec_c[VEC_L][2] == '0);
		zn_c = (vec_c[VEC_N][0] == '0) && (vec_c[VEC_N][1] == '0) && (vec_c[VEC_N][2] == '0);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			vec_s1   <= vec_c;
			col_s1   <= col_c;
			degen_s1 <= zl_c || zn_c;
		end
	end

	// Stage 2: largest component magnitude of each vector.
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			max_c[a] = mag(vec_s1[a][0]);
			if (mag(vec_s1[a][1]) > max_c[a]) max_c[a] = mag(vec_s1[a][1]);
			if (mag(vec_s1[a][2]) > max_c[a]) max_c[a] = mag(vec_s1[a][2]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			vec_s2   <= vec_s1;
			max_s2   <= max_c;
			col_s2   <= col_s1;
			degen_s2 <= degen_s1;
		end
	end

	// Stage 3: shift each vector so its largest component fits in 16 bits.
	always_comb begin
		logic [KW-1:0] pos;
		logic [KW-1:0] k;
		logic signed [VW-1:0] sh;
		for (int a = 0; a < 3; a++) begin
			pos = '0;
			for (int b = 0; b < VW; b++) begin
				if (max_s2[a][b]) pos = KW'(b);
			end
			k = (pos > KW'(RED_W - 2)) ? KW'(pos - KW'(RED_W - 2)) : '0;
			for (int j = 0; j < 3; j++) begin
				sh = vec_s2[a][j] >>> k;
				red_c[a][j] = sh[RED_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			red_s3   <= red_c;
			col_s3   <= col_s2;
			degen_s3 <= degen_s2;
		end
	end

	// Stage 4: component products for the four dot products.
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			lnp_c[j] = red_s3[VEC_L][j] * red_s3[VEC_N][j];
			vnp_c[j] = red_s3[VEC_V][j] * red_s3[VEC_N][j];
			llp_c[j] = red_s3[VEC_L][j] * red_s3[VEC_L][j];
			nnp_c[j] = red_s3[VEC_N][j] * red_s3[VEC_N][j];
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			lnp_s4   <= lnp_c;
			vnp_s4   <= vnp_c;
			llp_s4   <= llp_c;
			nnp_s4   <= nnp_c;
			col_s4   <= col_s3;
			degen_s4 <= degen_s3;
		end
	end

	// Stage 5: dot sums and the two-sided flip.
	always_comb begin
		dln_c = 34'(lnp_s4[0]) + 34'(lnp_s4[1]) + 34'(lnp_s4[2]);
		dvn_c = 34'(vnp_s4[0]) + 34'(vnp_s4[1]) + 34'(vnp_s4[2]);
		dd_c = dvn_c[33] ? -dln_c : dln_c;
		ll_c = unsigned'(llp_s4[0]) + unsigned'(llp_s4[1]) + unsigned'(llp_s4[2]);
		nn_c = unsigned'(nnp_s4[0]) + unsigned'(nnp_s4[1]) + unsigned'(nnp_s4[2]);
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			ll_s5         <= ll_c;
			nn_s5         <= nn_c;
			side_s5.dot   <= dd_c[31:0];
			side_s5.col   <= col_s4;
			side_s5.degen <= degen_s4;
			side_s5.dpos  <= (dd_c > 34'sd0) && !degen_s4;
		end
	end

	// Stage 6: product of the squared lengths.
	always_ff @(posedge clk) begin
		if (en[5]) begin
			prod_s6 <= SQ_IN_W'(ll_s5) * SQ_IN_W'(nn_s5);
			side_s6 <= side_s5;
		end
	end

	assign prod = prod_s6;
	assign side = side_s6;

endmodule

@@ hdl/lash_sqrt.sv @@
// Pipelined integer square root, two result bits per stage.
module lash_sqrt import lash_pkg::*; (
	input  logic                 clk,
	input  logic [SQ_ST-1:0]     en,
	input  logic [SQ_IN_W-1:0]   x,
	input  side_t                side_in,
	output logic [ROOT_W-1:0]    root,
	output side_t                side_out
);

	localparam int REM_W = ROOT_W + 3;

	logic [SQ_IN_W-1:0] sq_x_s    [SQ_ST];
	logic [REM_W-1:0]   sq_rem_s  [SQ_ST];
	logic [ROOT_W-1:0]  sq_root_s [SQ_ST];
	side_t              sq_side_s [SQ_ST];

	for (genvar s = 0; s < SQ_ST; s++) begin : g_st
		logic [SQ_IN_W-1:0] xi;
		logic [REM_W-1:0]   ri;
		logic [ROOT_W-1:0]  qi;
		side_t              si;
		logic [REM_W-1:0]   r_a, r_b;
		logic [ROOT_W-1:0]  q_a, q_b;

		if (s == 0) begin : g_first
			assign xi = x;
			assign ri = '0;
			assign qi = '0;
			assign si = side_in;
		end else begin : g_next
			assign xi = sq_x_s[s-1];
			assign ri = sq_rem_s[s-1];
			assign qi = sq_root_s[s-1];
			assign si = sq_side_s[s-1];
		end

		// Two restoring steps on the next four operand bits.
		always_comb begin
			logic [REM_W-1:0] t;
			r_a = {ri[REM_W-3:0], xi[SQ_IN_W-1:SQ_IN_W-2]};
			t = {1'b0, qi, 2'b01};
			if (r_a >= t) begin
				r_a = r_a - t;
				q_a = {qi[ROOT_W-2:0], 1'b1};
			end else begin
				q_a = {qi[ROOT_W-2:0], 1'b0};
			end
			r_b = {r_a[REM_W-3:0], xi[SQ_IN_W-3:SQ_IN_W-4]};
			t = {1'b0, q_a, 2'b01};
			if (r_b >= t) begin
				r_b = r_b - t;
				q_b = {q_a[ROOT_W-2:0], 1'b1};
			end else begin
				q_b = {q_a[ROOT_W-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk) begin
			if (en[s]) begin
				sq_x_s[s]    <= {xi[SQ_IN_W-5:0], 4'b0000};
				sq_rem_s[s]  <= r_b;
				sq_root_s[s] <= q_b;
				sq_side_s[s] <= si;
			end
		end
	end

	assign root     = sq_root_s[SQ_ST-1];
	assign side_out = sq_side_s[SQ_ST-1];

endmodule

@@ hdl/lash_div.sv @@
// Pipelined restoring divider: color times dot over the norm, one bit per stage.
module lash_div import lash_pkg::*; (
	input  logic                         clk,
	input  logic [DIV_ST-1:0]            en,
	input  logic [ROOT_W-1:0]            q,
	input  side_t                        side_in,
	output logic [2:0][DIV_BITS-1:0]     quot,
	output logic [2:0]                   ovf,
	output side_t                        side_out
);

	localparam int NUM_W = ROOT_W + 8;

	logic [ROOT_W-1:0]   dv_rem_s  [DIV_ST][3];
	logic [DIV_BITS-1:0] dv_lo_s   [DIV_ST][3];
	logic [DIV_BITS-1:0] dv_quot_s [DIV_ST][3];
	logic [2:0]          dv_ovf_s  [DIV_ST];
	logic [ROOT_W-1:0]   dv_q_s    [DIV_ST];
	side_t               dv_side_s [DIV_ST];

	logic [NUM_W-1:0] num_c [3];
	logic [2:0] ovf_c;
	side_t side_c;

	// Stage 0: numerators and the quotient range check.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			num_c[c] = NUM_W'(side_in.col[c]) * NUM_W'(side_in.dot);
			ovf_c[c] = ROOT_W'(num_c[c][NUM_W-1:DIV_BITS]) >= q;
		end
		side_c = side_in;
		side_c.dpos = side_in.dpos && (q != '0);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int c = 0; c < 3; c++) begin
				dv_rem_s[0][c]  <= ROOT_W'(num_c[c][NUM_W-1:DIV_BITS]);
				dv_lo_s[0][c]   <= num_c[c][DIV_BITS-1:0];
				dv_quot_s[0][c] <= '0;
			end
			dv_ovf_s[0]  <= ovf_c;
			dv_q_s[0]    <= q;
			dv_side_s[0] <= side_c;
		end
	end

	// One quotient bit per stage.
	for (genvar s = 1; s < DIV_ST; s++) begin : g_st
		logic [ROOT_W-1:0]   rem_n  [3];
		logic [DIV_BITS-1:0] quot_n [3];

		always_comb begin
			logic [ROOT_W:0] t;
			for (int c = 0; c < 3; c++) begin
				t = {dv_rem_s[s-1][c], dv_lo_s[s-1][c][DIV_BITS-1]};
				if (t >= {1'b0, dv_q_s[s-1]}) begin
					t = t - {1'b0, dv_q_s[s-1]};
					quot_n[c] = {dv_quot_s[s-1][c][DIV_BITS-2:0], 1'b1};
				end else begin
					quot_n[c] = {dv_quot_s[s-1][c][DIV_BITS-2:0], 1'b0};
				end
				rem_n[c] = t[ROOT_W-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en[s]) begin
				for (int c = 0; c < 3; c++) begin
					dv_rem_s[s][c]  <= rem_n[c];
					dv_lo_s[s][c]   <= {dv_lo_s[s-1][c][DIV_BITS-2:0], 1'b0};
					dv_quot_s[s][c] <= quot_n[c];
				end
				dv_ovf_s[s]  <= dv_ovf_s[s-1];
				dv_q_s[s]    <= dv_q_s[s-1];
				dv_side_s[s] <= dv_side_s[s-1];
			end
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			quot[c] = dv_quot_s[DIV_ST-1][c];
		end
	end
	assign ovf      = dv_ovf_s[DIV_ST-1];
	assign side_out = dv_side_s[DIV_ST-1];

endmodule

@@ hdl/lash_out.sv @@
// Output stages: diffuse clamp, ambient sum, color scaling and the divide by 255.
module lash_out import lash_pkg::*; (
	input  logic                     clk,
	input  logic [OUT_ST-1:0]        en,
	input  logic [2:0][DIV_BITS-1:0] quot,
	input  logic [2:0]               ovf,
	input  side_t                    side,
	input  logic [2:0][7:0]          amb,
	output shade_out_t               result
);

	logic [16:0] y_c [3];
	logic [16:0] y_s1 [3];
	logic degen_s1;
	logic [16:0] res_c [3];
	shade_out_t out_s2;

	// Stage 1: clamp the diffuse term, add the ambient term and scale by the surface color.
	always_comb begin
		logic [7:0] diff;
		for (int c = 0; c < 3; c++) begin
			if (!side.dpos) begin
				diff = '0;
			end else if (ovf[c] || (quot[c] > DIV_BITS'(side.col[c]))) begin
				diff = side.col[c];
			end else begin
				diff = quot[c][7:0];
			end
			y_c[c] = 17'(side.col[c]) * (17'(amb[c]) + 17'(diff));
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			y_s1     <= y_c;
			degen_s1 <= side.degen;
		end
	end

	// Stage 2: y * 256 / 255 = y + y / 255, quotient estimate plus one correction.
	always_comb begin
		logic [25:0] p257;
		logic [9:0]  q0;
		logic [17:0] r;
		for (int c = 0; c < 3; c++) begin
			p257 = {1'b0, y_s1[c], 8'b0} + 26'(y_s1[c]);
			q0 = p257[25:16];
			r = 18'(y_s1[c]) - (18'({q0, 8'b0}) - 18'(q0));
			res_c[c] = y_s1[c] + 17'(q0) + 17'(r >= 18'd255);
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			out_s2.shade_red   <= res_c[0];
			out_s2.shade_green <= res_c[1];
			out_s2.shade_blue  <= res_c[2];
			out_s2.degenerate  <= degen_s1;
		end
	end

	assign result = out_s2;

endmodule

@@ hdl/lambert_ambient_shader_top.sv @@
// Top level of the Lambert diffuse plus ambient shader pipeline.
//
//   port group   direction  handshake              payload
//   in_*         in         in_valid / in_ready    shade_in_t
//   out_*        out        out_valid / out_ready  shade_out_t
//   cfg_*        in         cfg_wr_en (no wait)    cfg_index, cfg_data
//
// One transaction per cycle is accepted while in_ready is high; the pipeline has 34 register
// stages, a length set by the 16-stage square root and the 10-stage divider.
// Every stage moves while any stage at or after it is empty or out_ready is high,
// so bubbles are squeezed out and a stalled output still lets new input in while a stage is empty.
// Reset empties the pipeline and clears all configuration registers to zero.
module lambert_ambient_shader_top import lash_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  shade_in_t          in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output shade_out_t         out_data,
	input  logic               cfg_wr_en,
	input  logic [2:0]         cfg_index,
	input  logic [FIELD_W-1:0] cfg_data
);

	localparam int SQ_LO  = FRONT_ST;
	localparam int DIV_LO = FRONT_ST + SQ_ST;
	localparam int OUT_LO = FRONT_ST + SQ_ST + DIV_ST;

	logic [2:0][FIELD_W-1:0] light_q;
	logic [2:0][FIELD_W-1:0] camera_q;
	logic [16:0] amb_lvl_q;
	logic [23:0] amb_rgb_q;
	logic [2:0][7:0] amb_q;

	logic [NUM_ST-1:0] vld_q;
	logic [NUM_ST-1:0] en;

	logic [SQ_IN_W-1:0] prod;
	side_t side_f, side_q, side_d;
	logic [ROOT_W-1:0] root;
	logic [2:0][DIV_BITS-1:0] quot;
	logic [2:0] ovf;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_q   <= '0;
			camera_q  <= '0;
			amb_lvl_q <= '0;
			amb_rgb_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LIGHT_X:  light_q[0]  <= cfg_data;
				REG_LIGHT_Y:  light_q[1]  <= cfg_data;
				REG_LIGHT_Z:  light_q[2]  <= cfg_data;
				REG_CAMERA_X: camera_q[0] <= cfg_data;
				REG_CAMERA_Y: camera_q[1] <= cfg_data;
				REG_CAMERA_Z: camera_q[2] <= cfg_data;
				REG_AMB_LVL:  amb_lvl_q   <= cfg_data[16:0];
				REG_AMB_RGB:  amb_rgb_q   <= cfg_data[23:0];
				default:      amb_rgb_q   <= amb_rgb_q;
			endcase
		end
	end

	// Ambient term per channel (red first), recomputed from the registers every cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amb_q <= '0;
		end else begin
			for (int c = 0; c < 3; c++) begin
				logic [16:0] lvl;
				logic [24:0] p;
				lvl = (amb_lvl_q > 17'd65536) ? 17'd65536 : amb_lvl_q;
				p = 25'(lvl) * 25'(amb_rgb_q[8*(2-c) +: 8]);
				amb_q[c] <= p[23:16];
			end
		end
	end

	// Stage enables: a stage moves when it or a later stage has a hole or the output drains.
	always_comb begin
		logic [NUM_ST-1:0] lowm;
		for (int i = 0; i < NUM_ST; i++) begin
			lowm = {NUM_ST{1'b1}} >> (NUM_ST - i);
			en[i] = out_ready || !(&(vld_q | lowm));
		end
	end

	// Valid bits follow the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 0; i < NUM_ST; i++) begin
				if (en[i]) begin
					vld_q[i] <= (i == 0) ? in_valid : vld_q[(i == 0) ? 0 : i - 1];
				end
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_q[NUM_ST-1];

	lash_front #(.CW(COORD_WIDTH)) u_front (
		.clk    (clk),
		.en     (en[FRONT_ST-1:0]),
		.item   (in_data),
		.light  (light_q),
		.camera (camera_q),
		.prod   (prod),
		.side   (side_f)
	);

	lash_sqrt u_sqrt (
		.clk      (clk),
		.en       (en[DIV_LO-1:SQ_LO]),
		.x        (prod),
		.side_in  (side_f),
		.root     (root),
		.side_out (side_q)
	);

	lash_div u_div (
		.clk      (clk),
		.en       (en[OUT_LO-1:DIV_LO]),
		.q        (root),
		.side_in  (side_q),
		.quot     (quot),
		.ovf      (ovf),
		.side_out (side_d)
	);

	lash_out u_out (
		.clk    (clk),
		.en     (en[NUM_ST-1:OUT_LO]),
		.quot   (quot),
		.ovf    (ovf),
		.side   (side_d),
		.amb    (amb_q),
		.result (out_data)
	);

	// A hole anywhere in the pipeline must open the input.
	a_hole_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!(&vld_q) |-> in_ready)
		else $error("input stalled while the pipeline has an empty stage");

	// Occupancy changes only by accepted and delivered transactions.
	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> $countones(vld_q) == $past($countones(vld_q))
			+ $past(int'(in_valid && in_ready)) - $past(int'(out_valid && out_ready)))
		else $error("pipeline occupancy lost or duplicated a transaction");

	// Shaded values never exceed 510 in Q9.8.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.shade_red <= 17'd130560)
			&& (out_data.shade_green <= 17'd130560)
			&& (out_data.shade_blue <= 17'd130560))
		else $error("shaded value out of range");

endmodule
